>>> rtl/matrix4_column_transform_unit_macros.svh
// Assertion macros used by the checker of the matrix column transform unit
`ifndef MATRIX4_COLUMN_TRANSFORM_UNIT_MACROS_SVH
`define MATRIX4_COLUMN_TRANSFORM_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset
`define M4CT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger
`define M4CT_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/m4ct_pkg.sv
// Shared types, widths and codes for the matrix column transform unit
`default_nettype none

package m4ct_pkg;

  localparam int unsigned ElemW       = 32;
  localparam int unsigned ColW        = 2;
  localparam int unsigned NumRows     = 4;
  localparam int unsigned ProdW       = 2 * ElemW;
  localparam int unsigned SumW        = ProdW + 2;
  localparam int unsigned FracBitsDef = 16;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic        [ColW-1:0]  col_t;

  localparam elem_t ElemMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam elem_t ElemMin = {1'b1, {(ElemW-1){1'b0}}};

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_MUL  = 1'b1
  } func_e;

  // Stage enables handed to each row lane
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

endpackage

`default_nettype wire

>>> rtl/m4ct_if.sv
// Valid/ready channel interfaces for input items and result items
`default_nettype none

interface m4ct_in_if;
  import m4ct_pkg::*;
  logic  valid;
  logic  ready;
  func_e func;
  col_t  column;
  elem_t elem_0;
  elem_t elem_1;
  elem_t elem_2;
  elem_t elem_3;
  modport source (output valid, func, column, elem_0, elem_1, elem_2, elem_3, input ready);
  modport sink   (input valid, func, column, elem_0, elem_1, elem_2, elem_3, output ready);
endinterface

interface m4ct_out_if;
  import m4ct_pkg::*;
  logic  valid;
  logic  ready;
  col_t  out_column;
  elem_t out_0;
  elem_t out_1;
  elem_t out_2;
  elem_t out_3;
  logic  saturated;
  modport source (output valid, out_column, out_0, out_1, out_2, out_3, saturated, input ready);
  modport sink   (input valid, out_column, out_0, out_1, out_2, out_3, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/m4ct_lane.sv
// One row lane: four products, their sum, then floor shift and clamp
`default_nettype none

module m4ct_lane #(
  parameter int unsigned FracBits = m4ct_pkg::FracBitsDef
) (
  input  wire                logic clk_i,
  input  m4ct_pkg::pipe_en_t en_i,
  input  m4ct_pkg::elem_t    row_i [m4ct_pkg::NumRows],
  input  m4ct_pkg::elem_t    vec_i [m4ct_pkg::NumRows],
  output m4ct_pkg::elem_t    res_o,
  output logic               sat_o
);
  import m4ct_pkg::*;

  logic signed [ProdW-1:0]   prod_d [NumRows];
  logic signed [ProdW-1:0]   prod_q [NumRows];
  logic signed [SumW-1:0]    sum_d;
  logic signed [SumW-1:0]    sum_q;
  logic signed [SumW-1:0]    shifted;
  logic        [SumW-ElemW:0] upper;
  logic                      in_range;

  always_comb begin
    for (int k = 0; k < NumRows; k++) begin
      prod_d[k] = ProdW'(row_i[k]) * ProdW'(vec_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_q <= prod_d;
    end
  end

  assign sum_d = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]) + SumW'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sum_q <= sum_d;
    end
  end

  // Fits when every bit above the result's sign bit matches it
  assign shifted  = sum_q >>> FracBits;
  assign upper    = shifted[SumW-1:ElemW-1];
  assign in_range = (&upper) || !(|upper);

  always_comb begin
    if (in_range) begin
      res_o = shifted[ElemW-1:0];
    end else if (shifted[SumW-1]) begin
      res_o = ElemMin;
    end else begin
      res_o = ElemMax;
    end
  end

  assign sat_o = !in_range;

endmodule

`default_nettype wire

>>> rtl/m4ct_merge.sv
// Output stage: gathers the four lane results into one registered transfer
`default_nettype none

module m4ct_merge (
  input  wire             logic clk_i,
  input  wire             logic rst_ni,
  input  logic            valid_i,
  input  m4ct_pkg::col_t  col_i,
  input  m4ct_pkg::elem_t res_i [m4ct_pkg::NumRows],
  input  logic            sat_i [m4ct_pkg::NumRows],
  output logic            ready_o,
  m4ct_out_if.source      out_o
);
  import m4ct_pkg::*;

  logic  valid_q;
  col_t  col_q;
  elem_t res_q [NumRows];
  logic  sat_q;
  logic  sat_any;

  assign ready_o = !valid_q || out_o.ready;
  assign sat_any = sat_i[0] || sat_i[1] || sat_i[2] || sat_i[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      col_q <= col_i;
      res_q <= res_i;
      sat_q <= sat_any;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_column = col_q;
  assign out_o.out_0      = res_q[0];
  assign out_o.out_1      = res_q[1];
  assign out_o.out_2      = res_q[2];
  assign out_o.out_3      = res_q[3];
  assign out_o.saturated  = sat_q;

endmodule

`default_nettype wire

>>> rtl/matrix4_column_transform_unit.sv
// Matrix column transform unit: 4x4 Q-format matrix times column vector.
// Four row lanes compute the dot products side by side; a multiply item passes through the
// product, sum and output registers. Throughput: one item per cycle unless the output stalls.
// Load items write one column of the stored matrix and give no result.
// Reset clears the stored matrix to zero and empties the pipeline.
`default_nettype none

module matrix4_column_transform_unit #(
  parameter int unsigned FracBits = m4ct_pkg::FracBitsDef
) (
  input  wire        logic clk_i,
  input  wire        logic rst_ni,
  m4ct_in_if.sink    in_i,
  m4ct_out_if.source out_o
);
  import m4ct_pkg::*;

  elem_t    matrix_q [NumRows*NumRows];
  elem_t    in_elem  [NumRows];
  elem_t    lane_row [NumRows][NumRows];
  elem_t    lane_res [NumRows];
  logic     lane_sat [NumRows];
  logic     v1_q, v2_q;
  col_t     c1_q, c2_q;
  logic     en1, en2, en3;
  logic     in_xfer, do_load, do_mul;
  pipe_en_t lane_en;

  assign in_elem[0] = in_i.elem_0;
  assign in_elem[1] = in_i.elem_1;
  assign in_elem[2] = in_i.elem_2;
  assign in_elem[3] = in_i.elem_3;

  // A stage advances when it is empty or the next one advances
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign do_load    = in_xfer && (in_i.func == FUNC_LOAD);
  assign do_mul     = in_xfer && (in_i.func == FUNC_MUL);
  assign lane_en    = '{s1: en1, s2: en2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRows*NumRows; i++) begin
        matrix_q[i] <= '0;
      end
    end else if (do_load) begin
      for (int c = 0; c < NumRows; c++) begin
        for (int r = 0; r < NumRows; r++) begin
          if (in_i.column == ColW'(c)) begin
            matrix_q[c*NumRows + r] <= in_elem[r];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= do_mul;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q <= in_i.column;
    end
    if (en2) begin
      c2_q <= c1_q;
    end
  end

  // Lane r sees row r: entry k*4+r for each column k
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < NumRows; k++) begin
        lane_row[r][k] = matrix_q[k*NumRows + r];
      end
    end
  end

  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    m4ct_lane #(
      .FracBits (FracBits)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .row_i (lane_row[r]),
      .vec_i (in_elem),
      .res_o (lane_res[r]),
      .sat_o (lane_sat[r])
    );
  end

  m4ct_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .col_i   (c2_q),
    .res_i   (lane_res),
    .sat_i   (lane_sat),
    .ready_o (en3),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/m4ct_checker.sv
// Port-level checks for the matrix column transform unit, bound to the top level
`default_nettype none

`include "matrix4_column_transform_unit_macros.svh"

module m4ct_checker (
  input wire             logic clk_i,
  input wire             logic rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input m4ct_pkg::elem_t out_0_i,
  input m4ct_pkg::elem_t out_1_i,
  input m4ct_pkg::elem_t out_2_i,
  input m4ct_pkg::elem_t out_3_i,
  input logic            saturated_i
);
  import m4ct_pkg::*;

  // Input side stalls only when the whole pipeline is backed up
  `M4CT_ASSERT(a_stall_full, clk_i, rst_ni, !in_ready_i |-> (out_valid_i && !out_ready_i), "input stalled without output backpressure")

  // A clamped result must show a range end in some row
  `M4CT_ASSERT(a_sat_clamp, clk_i, rst_ni, (out_valid_i && saturated_i) |-> (out_0_i == ElemMax || out_0_i == ElemMin || out_1_i == ElemMax || out_1_i == ElemMin || out_2_i == ElemMax || out_2_i == ElemMin || out_3_i == ElemMax || out_3_i == ElemMin), "saturated flag without clamped row")

  // Hold a pending result until its transfer
  `M4CT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped before transfer")

endmodule

bind matrix4_column_transform_unit m4ct_checker u_m4ct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_0_i     (out_o.out_0),
  .out_1_i     (out_o.out_1),
  .out_2_i     (out_o.out_2),
  .out_3_i     (out_o.out_3),
  .saturated_i (out_o.saturated)
);

`default_nettype wire
